/* hw/rtl/utt_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by utt_step, utt_out_buf, the top level and the testbench.
`timescale 1ns / 1ps

package utt_pkg;

   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned ACCUM_W = 21;
   localparam int unsigned TOGO_W  = 3;

   localparam logic [UNIT_W-1:0]  QMARK        = 16'h003F;
   localparam logic [UNIT_W-1:0]  SURR_HI_BASE = 16'hD800;
   localparam logic [UNIT_W-1:0]  SURR_LO_BASE = 16'hDC00;
   localparam logic [ACCUM_W-1:0] SUPP_BASE    = 21'h010000;

   // Bytes still owed after each kind of lead byte.
   localparam logic [TOGO_W-1:0] TOGO_NONE  = 3'd0;
   localparam logic [TOGO_W-1:0] TOGO_TWO   = 3'd1;
   localparam logic [TOGO_W-1:0] TOGO_THREE = 3'd2;
   localparam logic [TOGO_W-1:0] TOGO_FOUR  = 3'd3;
   localparam logic [TOGO_W-1:0] TOGO_FIVE  = 3'd4;

   // One outgoing UTF-16 unit with its flags.
   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              last_of_run;
      logic              text_done;
   } unit_type;

   // Everything one input byte produces.
   typedef struct packed {
      logic [1:0] count;
      unit_type   first;
      unit_type   second;
   } step_result_type;

endpackage

/* hw/rtl/utt_ifs.sv */
// Valid/ready channel interfaces for the transcoder's request and result sides.
// No dependencies.
`timescale 1ns / 1ps

interface utt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        last_of_run;
   logic        text_done;

   modport source (output valid, output code_unit, output last_of_run, output text_done,
                   input ready);
   modport sink   (input valid, input code_unit, input last_of_run, input text_done,
                   output ready);
endinterface

/* hw/rtl/utt_step.sv */
// Decoder state and the per-byte step: sequence tracking and UTF-16 encoding.
// Depends on utt_pkg.
`timescale 1ns / 1ps

module utt_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [7:0]                 in_byte,
   input  logic                       end_of_text,
   output utt_pkg::step_result_type   result
);

   logic [utt_pkg::TOGO_W-1:0]  togo_ff, togo_in;
   logic [utt_pkg::ACCUM_W-1:0] accum_ff, accum_in;
   logic                        ok_ff, ok_in;

   logic [utt_pkg::TOGO_W-1:0]  togo_next;
   logic [utt_pkg::ACCUM_W-1:0] accum_next;
   logic [utt_pkg::ACCUM_W-1:0] cp_off;
   logic                        ok_next;
   logic                        is_cont;
   logic                        finish;
   logic [1:0]                  count;
   logic [utt_pkg::UNIT_W-1:0]  unit0;
   logic [utt_pkg::UNIT_W-1:0]  unit1;

   assign is_cont = (in_byte[7:6] == 2'b10);

   always_comb begin
      togo_next  = togo_ff;
      accum_next = accum_ff;
      ok_next    = ok_ff;
      finish     = 1'b0;
      count      = 2'd0;
      unit0      = utt_pkg::QMARK;
      unit1      = utt_pkg::QMARK;
      cp_off     = accum_ff - utt_pkg::SUPP_BASE;

      if (togo_ff == utt_pkg::TOGO_NONE) begin
         priority if (in_byte[7] == 1'b0) begin
            count = 2'd1;
            unit0 = {8'h00, in_byte};
         end else if (in_byte[7:6] == 2'b10) begin
            // stray continuation byte where a lead belongs
            count = 2'd1;
         end else if (in_byte[7:5] == 3'b110) begin
            togo_next  = utt_pkg::TOGO_TWO;
            accum_next = {16'd0, in_byte[4:0]};
            ok_next    = 1'b1;
         end else if (in_byte[7:4] == 4'b1110) begin
            togo_next  = utt_pkg::TOGO_THREE;
            accum_next = {17'd0, in_byte[3:0]};
            ok_next    = 1'b1;
         end else if (in_byte[7:3] == 5'b11110) begin
            togo_next  = utt_pkg::TOGO_FOUR;
            accum_next = {18'd0, in_byte[2:0]};
            ok_next    = 1'b1;
         end else begin
            togo_next  = utt_pkg::TOGO_FIVE;
            accum_next = '0;
            ok_next    = 1'b0;
         end
      end else begin
         accum_next = {accum_ff[utt_pkg::ACCUM_W-7:0], in_byte[5:0]};
         ok_next    = ok_ff & is_cont;
         togo_next  = togo_ff - 3'd1;
         finish     = (togo_next == utt_pkg::TOGO_NONE);
      end

      if (finish) begin
         cp_off = accum_next - utt_pkg::SUPP_BASE;
         priority if (!ok_next) begin
            count = 2'd1;
         end else if (accum_next[20:16] == 5'd0) begin
            count = 2'd1;
            unit0 = accum_next[15:0];
         end else begin
            count = 2'd2;
            unit0 = utt_pkg::SURR_HI_BASE + {5'd0, cp_off[20:10]};
            unit1 = utt_pkg::SURR_LO_BASE | {6'd0, cp_off[9:0]};
         end
         accum_next = '0;
         ok_next    = 1'b0;
      end

      // string ends inside an open sequence
      if (end_of_text && (togo_next != utt_pkg::TOGO_NONE)) begin
         count      = 2'd1;
         unit0      = utt_pkg::QMARK;
         togo_next  = utt_pkg::TOGO_NONE;
         accum_next = '0;
         ok_next    = 1'b0;
      end
   end

   always_comb begin
      togo_in  = togo_ff;
      accum_in = accum_ff;
      ok_in    = ok_ff;
      if (advance) begin
         togo_in  = togo_next;
         accum_in = accum_next;
         ok_in    = ok_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         togo_ff  <= '0;
         accum_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         togo_ff  <= togo_in;
         accum_ff <= accum_in;
         ok_ff    <= ok_in;
      end
   end

   always_comb begin
      result.count              = count;
      result.first.code_unit    = unit0;
      result.first.last_of_run  = (count == 2'd1);
      result.first.text_done    = (count == 2'd1) && end_of_text;
      result.second.code_unit   = unit1;
      result.second.last_of_run = 1'b1;
      result.second.text_done   = end_of_text;
   end

endmodule

/* hw/rtl/utt_out_buf.sv */
// Result register: holds up to two units from one request and drains one per cycle
// while rsp_ready is high. Depends on utt_pkg.
`timescale 1ns / 1ps

module utt_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  utt_pkg::step_result_type result,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output utt_pkg::unit_type        rsp_unit,
   output logic                     can_load
);

   logic [1:0]        cnt_ff, cnt_in;
   utt_pkg::unit_type head_ff, head_in;
   utt_pkg::unit_type tail_ff, tail_in;
   logic              pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_unit  = head_ff;
   assign pop       = rsp_valid && rsp_ready;
   // free once whatever is held leaves this cycle
   assign can_load  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      if (load) begin
         cnt_in  = result.count;
         head_in = result.first;
         tail_in = result.second;
      end else if (pop) begin
         cnt_in  = cnt_ff - 2'd1;
         head_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

/* hw/rtl/utf8_to_utf16_transcoder_unit.sv */
// Top level of the UTF-8 to UTF-16 transcoder.
// Depends on utt_pkg, utt_ifs, utt_step and utt_out_buf.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per request and returns UTF-16 code units one per cycle
// while rsp.ready is high. A request is taken every cycle as long as the result
// register empties in that cycle; a byte that finishes a code point at or above
// 0x10000 yields a surrogate pair, and the next request waits until the second
// unit of the pair leaves. Results are registered and appear in the cycle after
// the request that causes them. A bad byte inside a sequence, a stray continuation
// byte, a five-byte lead or a cut-short end gives one '?' (0x3F); every request
// flagged end_of_text gives at least one unit, the last with text_done set.
module utf8_to_utf16_transcoder_unit (
   input  logic      clock,
   input  logic      reset,
   utt_req_if.sink   req,
   utt_rsp_if.source rsp
);

   utt_pkg::step_result_type step_result;
   utt_pkg::unit_type        rsp_unit;
   logic                     can_load;
   logic                     accept;

   // no request is taken while reset is held
   assign req.ready = can_load && !reset;
   assign accept    = req.valid && req.ready;

   utt_step u_step (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .in_byte     (req.in_byte),
      .end_of_text (req.end_of_text),
      .result      (step_result)
   );

   utt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result    (step_result),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_unit  (rsp_unit),
      .can_load  (can_load)
   );

   assign rsp.code_unit   = rsp_unit.code_unit;
   assign rsp.last_of_run = rsp_unit.last_of_run;
   assign rsp.text_done   = rsp_unit.text_done;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the UTF-8 to UTF-16 transcoder: random and directed byte
// strings go in, every UTF-16 unit that comes out is checked against a local predictor.
// Depends on utt_pkg, utt_ifs and utf8_to_utf16_transcoder_unit.
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_HALF       = 2;
   localparam int ITEM_TARGET    = 1350;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int STALL_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int MAX_REPORTS    = 10;

   // Running copy of the decoder state; expected units wait in order of arrival.
   class utf16_scoreboard;
      logic [utt_pkg::TOGO_W-1:0]  owed;
      logic [utt_pkg::ACCUM_W-1:0] accum;
      logic                        seq_valid;
      utt_pkg::unit_type           expected_units[$];
      int                          mismatches;
      int                          units_checked;
      int                          pair_count;
      int                          qmark_count;
      int                          text_count;

      function new();
         owed          = utt_pkg::TOGO_NONE;
         accum         = '0;
         seq_valid     = 1'b0;
         mismatches    = 0;
         units_checked = 0;
         pair_count    = 0;
         qmark_count   = 0;
         text_count    = 0;
      endfunction

      function void note_byte(logic [7:0] in_byte, logic eot);
         logic [utt_pkg::UNIT_W-1:0]  units [2];
         logic [utt_pkg::ACCUM_W-1:0] offset;
         int                          n;
         utt_pkg::unit_type           u;
         n = 0;
         units[0] = '0;
         units[1] = '0;
         if (owed == utt_pkg::TOGO_NONE) begin
            if (in_byte < 8'h80) begin
               units[0] = {8'h00, in_byte};
               n = 1;
            end else if (in_byte < 8'hC0) begin
               // continuation byte with no open sequence
               units[0] = utt_pkg::QMARK;
               n = 1;
               qmark_count++;
            end else if (in_byte < 8'hE0) begin
               owed = utt_pkg::TOGO_TWO;
               accum = {16'h0, in_byte[4:0]};
               seq_valid = 1'b1;
            end else if (in_byte < 8'hF0) begin
               owed = utt_pkg::TOGO_THREE;
               accum = {17'h0, in_byte[3:0]};
               seq_valid = 1'b1;
            end else if (in_byte < 8'hF8) begin
               owed = utt_pkg::TOGO_FOUR;
               accum = {18'h0, in_byte[2:0]};
               seq_valid = 1'b1;
            end else begin
               // five-byte form, always ends as '?'
               owed = utt_pkg::TOGO_FIVE;
               accum = '0;
               seq_valid = 1'b0;
            end
         end else begin
            if (in_byte[7:6] != 2'b10) seq_valid = 1'b0;
            accum = {accum[utt_pkg::ACCUM_W-7:0], in_byte[5:0]};
            owed = owed - 3'd1;
            if (owed == utt_pkg::TOGO_NONE) begin
               if (!seq_valid) begin
                  units[0] = utt_pkg::QMARK;
                  n = 1;
                  qmark_count++;
               end else if (accum < utt_pkg::SUPP_BASE) begin
                  units[0] = accum[utt_pkg::UNIT_W-1:0];
                  n = 1;
               end else begin
                  offset = accum - utt_pkg::SUPP_BASE;
                  units[0] = utt_pkg::SURR_HI_BASE + {5'h0, offset[20:10]};
                  units[1] = utt_pkg::SURR_LO_BASE + {6'h0, offset[9:0]};
                  n = 2;
                  pair_count++;
               end
               accum = '0;
               seq_valid = 1'b0;
            end
         end
         // text ended with a sequence still open
         if (eot && owed != utt_pkg::TOGO_NONE) begin
            units[0] = utt_pkg::QMARK;
            n = 1;
            qmark_count++;
            owed = utt_pkg::TOGO_NONE;
            accum = '0;
            seq_valid = 1'b0;
         end
         for (int k = 0; k < n; k++) begin
            u.code_unit   = units[k];
            u.last_of_run = (k == n - 1);
            u.text_done   = (k == n - 1) && eot;
            expected_units.push_back(u);
         end
         if (eot) text_count++;
      endfunction

      function void check_unit(utt_pkg::unit_type got);
         utt_pkg::unit_type want;
         units_checked++;
         if (expected_units.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb_top: unexpected unit %h/%b/%b", got.code_unit, got.last_of_run,
                        got.text_done);
            return;
         end
         want = expected_units.pop_front();
         if (got.code_unit !== want.code_unit || got.last_of_run !== want.last_of_run ||
             got.text_done !== want.text_done) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb_top: unit %0d: expected %h/%b/%b, got %h/%b/%b", units_checked,
                        want.code_unit, want.last_of_run, want.text_done,
                        got.code_unit, got.last_of_run, got.text_done);
         end
      endfunction
   endclass

   // {end_of_text, byte}
   localparam logic [8:0] DIRECTED_BYTES [26] = '{
      {1'b0, 8'h00}, {1'b1, 8'h7F},                               // ASCII extremes
      {1'b0, 8'hC2}, {1'b0, 8'hA9},                               // two-byte
      {1'b0, 8'hEF}, {1'b0, 8'hBF}, {1'b0, 8'hBF},                // three-byte max
      {1'b0, 8'hF0}, {1'b0, 8'h9F}, {1'b0, 8'h98}, {1'b0, 8'h80}, // surrogate pair
      {1'b0, 8'hF7}, {1'b0, 8'hBF}, {1'b0, 8'hBF}, {1'b1, 8'hBF}, // past U+10FFFF
      {1'b0, 8'hBF},                                              // stray continuation
      {1'b0, 8'hF8}, {1'b0, 8'h41}, {1'b0, 8'h42}, {1'b0, 8'h43},
      {1'b0, 8'h44},                                              // five-byte lead
      {1'b0, 8'hE2}, {1'b0, 8'h41}, {1'b0, 8'h82},                // bad byte inside
      {1'b0, 8'hE2}, {1'b1, 8'h82}                                // cut short by end
   };

   logic clock = 1'b0;
   logic reset;

   utt_req_if req_bus ();
   utt_rsp_if rsp_bus ();

   utf8_to_utf16_transcoder_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   utf16_scoreboard ledger = new();
   logic [7:0]      text_bytes[$];
   bit              no_idle = 1'b0;
   int              holdoff_asked = 0;
   int              holdoff_seen = 0;
   int              bytes_sent = 0;
   int              strings_sent = 0;
   int              idle_cycles = 0;

   always #(CLK_HALF) clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] lead_for(int len);
      case (len)
         2:       return 8'hC0 | 8'($urandom_range(0, 31));
         3:       return 8'hE0 | 8'($urandom_range(0, 15));
         4:       return 8'hF0 | 8'($urandom_range(0, 7));
         default: return 8'hF8 | 8'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   function automatic logic [7:0] non_cont_byte();
      int r;
      r = $urandom_range(0, 191);
      return (r < 128) ? 8'(r) : 8'(r + 64);
   endfunction

   // Mostly well-formed characters with random payload; the rest is noise.
   function automatic void add_char();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      len = 0;
      if (kind < 30) begin
         text_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 82) begin
         len = (kind < 45) ? 2 : (kind < 60) ? 3 : (kind < 78) ? 4 : 5;
         text_bytes.push_back(lead_for(len));
         for (int k = 1; k < len; k++)
            text_bytes.push_back((len == 5) ? 8'($urandom_range(0, 255)) : cont_byte());
      end else if (kind < 87) begin
         text_bytes.push_back(cont_byte());
      end else if (kind < 95) begin
         len = $urandom_range(2, 4);
         text_bytes.push_back(lead_for(len));
         for (int k = 1; k < len; k++)
            text_bytes.push_back($urandom_range(0, 1) ? non_cont_byte() : cont_byte());
      end else begin
         text_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic eot);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_byte     <= value;
      req_bus.end_of_text <= eot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_string();
      int nchars;
      int len;
      text_bytes.delete();
      nchars = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (nchars) add_char();
      if ($urandom_range(0, 99) < 15) begin
         len = $urandom_range(2, 5);
         text_bytes.push_back(lead_for(len));
         repeat ($urandom_range(0, len - 2)) text_bytes.push_back(cont_byte());
      end
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      strings_sent++;
   endtask

   // First edge lets the monitor book the last request before the queue is read.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (ledger.expected_units.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            ledger.note_byte(req_bus.in_byte, req_bus.end_of_text);
         if (rsp_bus.valid && rsp_bus.ready)
            ledger.check_unit('{rsp_bus.code_unit, rsp_bus.last_of_run, rsp_bus.text_done});
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when the sender asks for one.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_asked != holdoff_seen) begin
            holdoff_seen = holdoff_asked;
            rsp_bus.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.in_byte     <= 8'h00;
      req_bus.end_of_text <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
      wait_drained();

      while (bytes_sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if (strings_sent == 30) begin
            // results blocked while requests keep coming: input must back up
            holdoff_asked++;
            no_idle = 1'b1;
            repeat (6) send_string();
         end else begin
            send_string();
         end
         if (strings_sent == 60 || $urandom_range(0, 99) < 4) wait_drained();
      end

      no_idle = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d bytes in %0d strings, %0d UTF-16 units checked",
               bytes_sent, ledger.text_count, ledger.units_checked);
      $display("tb_top: %0d surrogate pairs, %0d replacement units, %0d mismatches",
               ledger.pair_count, ledger.qmark_count, ledger.mismatches);
      if (ledger.mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/utt_pkg.sv
hw/rtl/utt_ifs.sv
hw/rtl/utt_step.sv
hw/rtl/utt_out_buf.sv
hw/rtl/utf8_to_utf16_transcoder_unit.sv
sim/tb_top.sv
